// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// shared types and codes for the bounded deque with search
// ----------------------------------------------------------------------------
package bdq_pkg;

    // operation codes carried on the input tuser
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_FIND       = 3'd4
    } t_op;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADDR = 4'b0010,
        S_CHK  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

endpackage

// ===== rtl/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// bounded double-ended queue of words in a ring, with a linear value search
// ----------------------------------------------------------------------------
// Usage:
//   slave channel: one transaction per operation; tuser carries the operation
//   (push front, push back, pop front, pop back, find), tdata the word.
//   master channel: exactly one result transaction per operation with the
//   popped word, status, found flag, match position and count after it.
//   Path from acceptance to result valid: every operation passes the address
//   state and the done state; a pop on a non-empty queue adds one pass
//   through the check state for the read entry, and a find on a non-empty
//   queue adds one pass for each entry compared, up to the first match or the
//   last entry. The block works on one operation at a time; o_s_tready goes
//   high again once the result has moved into the output register, so a new
//   operation is not taken before the last result has left the sequencer.
//   A find walks the ring one entry a cycle through the single read port of
//   the entry store and one comparator.
//   Reset empties the queue (front pointer and count to zero) and drops any
//   pending result. When the receiver stalls, the result holds in the output
//   register; the next operation may be accepted and worked on meanwhile,
//   and its result waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave side
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [31:0]                i_s_tdata,   // value[31:0]
    input  logic [2:0]                 i_s_tuser,   // op[2:0]
    // master side
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // popped[31:0], position[PW-1:0], count[CW-1:0], zero fill to bytes
    output logic [((32 + $clog2(DEPTH) + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0]
                                       o_m_tdata,
    output logic [2:0]                 o_m_tuser    // status[1:0], found[2]
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int KW  = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int OW  = 32 + PW + CW;
    localparam int TDW = ((OW + 7) / 8) * 8;
    localparam int SW  = CW + 1;

    t_state           r_state, n_state;
    t_op              r_op, n_op;
    logic [KW-1:0]    r_word, n_word;
    logic [PW-1:0]    r_front, n_front;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx, n_idx;
    logic [31:0]      r_popped, n_popped;
    logic [1:0]       r_status, n_status;
    logic             r_found, n_found;
    logic [PW-1:0]    r_pos, n_pos;
    logic             r_o_valid, n_o_valid;
    logic [OW-1:0]    r_o_data, n_o_data;
    logic [2:0]       r_o_user, n_o_user;

    logic             w_full;
    logic             w_empty;
    logic             w_slot;
    logic             w_we;
    logic [CW-1:0]    w_off;
    logic [SW-1:0]    w_sum;
    logic [SW-1:0]    w_wrap;
    logic [PW-1:0]    w_ring;
    logic [KW-1:0]    w_rd_data;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_slot  = !r_o_valid || i_m_tready;

    // ring offset for the address unit
    always_comb begin
        w_off = '0;
        if (r_state == S_CHK) begin
            w_off = r_idx + CW'(1);
        end else begin
            case (r_op)
                OP_PUSH_FRONT: w_off = CW'(DEPTH - 1);
                OP_PUSH_BACK:  w_off = r_count;
                OP_POP_BACK:   w_off = r_count - CW'(1);
                default:       w_off = '0;
            endcase
        end
    end

    // shared ring address unit: front plus offset modulo depth
    assign w_sum  = SW'(r_front) + SW'(w_off);
    assign w_wrap = (w_sum >= SW'(DEPTH)) ? (w_sum - SW'(DEPTH)) : w_sum;
    assign w_ring = w_wrap[PW-1:0];

    assign w_we = (r_state == S_ADDR) && !w_full
               && ((r_op == OP_PUSH_FRONT) || (r_op == OP_PUSH_BACK));

    bdq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (KW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_wr_addr (w_ring),
        .i_wr_data (r_word),
        .i_rd_addr (w_ring),
        .o_rd_data (w_rd_data)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_word   = r_word;
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        n_popped = r_popped;
        n_status = r_status;
        n_found  = r_found;
        n_pos    = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_op     = t_op'(i_s_tuser);
                    n_word   = i_s_tdata[KW-1:0];
                    n_idx    = '0;
                    n_popped = '0;
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_state  = S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = S_DONE;
                case (r_op)
                    OP_PUSH_FRONT: begin
                        if (w_full) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            n_front = w_ring;
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_PUSH_BACK: begin
                        if (w_full) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            n_count = r_count + CW'(1);
                        end
                    end
                    OP_POP_FRONT: begin
                        if (w_empty) begin
                            n_status = ST_UNDERFLOW;
                        end else begin
                            n_front = (r_front == PW'(DEPTH - 1)) ? '0 : r_front + PW'(1);
                            n_count = r_count - CW'(1);
                            n_state = S_CHK;
                        end
                    end
                    OP_POP_BACK: begin
                        if (w_empty) begin
                            n_status = ST_UNDERFLOW;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_CHK;
                        end
                    end
                    OP_FIND: begin
                        if (!w_empty) begin
                            n_state = S_CHK;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_CHK: begin
                if (r_op == OP_FIND) begin
                    // one compare per cycle, next address already issued
                    if (w_rd_data == r_word) begin
                        n_found = 1'b1;
                        n_pos   = r_idx[PW-1:0];
                        n_state = S_DONE;
                    end else if (r_idx + CW'(1) == r_count) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx = r_idx + CW'(1);
                    end
                end else begin
                    n_popped = 32'(w_rd_data);
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_comb begin
        n_o_valid = r_o_valid;
        n_o_data  = r_o_data;
        n_o_user  = r_o_user;
        if ((r_state == S_DONE) && w_slot) begin
            n_o_valid = 1'b1;
            n_o_data  = {r_count, r_pos, r_popped};
            n_o_user  = {r_found, r_status};
        end else if (i_m_tready) begin
            n_o_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_word   <= n_word;
        r_idx    <= n_idx;
        r_popped <= n_popped;
        r_status <= n_status;
        r_found  <= n_found;
        r_pos    <= n_pos;
        r_o_data <= n_o_data;
        r_o_user <= n_o_user;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = TDW'(r_o_data);
    assign o_m_tuser  = r_o_user;

endmodule

// ===== rtl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data registered and valid in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
